/* src/tdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

    // Fixed widths of the external fields
    localparam int TAG_IN_W    = 16;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK = 2'd0,
        REQ_POP_BACK  = 2'd1,
        REQ_POP_FRONT = 2'd2,
        REQ_REMOVE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        req_t                  op;
        logic [TAG_IN_W-1:0]   tag;
    } request_t;

    typedef struct packed {
        logic [TAG_IN_W-1:0]    tag;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

/* src/tdq_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdq_engine #(
    parameter int LIST_DEPTH = 16,
    parameter int TAG_BITS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire tdq_pkg::request_t req,
    output logic                   req_ready,
    output logic                   res_valid,
    output tdq_pkg::result_t       res,
    input  wire logic              res_ready
);

    localparam int TAG_W     = (TAG_BITS < tdq_pkg::TAG_IN_W) ? TAG_BITS : tdq_pkg::TAG_IN_W;
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int AW        = $clog2(LIST_DEPTH);
    localparam int TAG_OUT_W = tdq_pkg::TAG_IN_W;
    localparam int CNT_OUT_W = tdq_pkg::COUNT_OUT_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        RESULT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     rd_addr_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic              pend_reg;
    logic              found_reg;
    logic              match_any_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  got_reg;
    tdq_pkg::status_t  status_reg;

    logic [TAG_W-1:0]  mem [LIST_DEPTH];
    logic [TAG_W-1:0]  rd_data_reg;

    logic [TAG_W-1:0]  req_tag;
    logic              push_we;
    logic              shift_we;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TAG_W-1:0]  mem_wdata;
    logic              issue;
    logic              data_match;
    logic              scan_done;

    assign req_tag = req.tag[TAG_W-1:0];

    // Reads walk upwards and shift writes land one below an address already read,
    // so a read never meets a pending write to the same entry.
    always_comb
    begin
        issue      = (state_reg == SCAN) && (rd_addr_reg < count_reg);
        data_match = pend_reg && !found_reg &&
                     (match_any_reg || ((tag_reg != '0) && (rd_data_reg == tag_reg)));
        scan_done  = (state_reg == SCAN) && !issue && !pend_reg;
        push_we    = (state_reg == IDLE) && req_valid && (req.op == tdq_pkg::REQ_PUSH_BACK) &&
                     (req_tag != '0) && (count_reg != CW'(LIST_DEPTH));
        shift_we   = pend_reg && found_reg;
        mem_we     = push_we || shift_we;
        if (shift_we)
        begin
            mem_waddr = pend_addr_reg - 1'b1;
            mem_wdata = rd_data_reg;
        end
        else
        begin
            mem_waddr = count_reg[AW-1:0];
            mem_wdata = req_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            pend_addr_reg <= '0;
            match_any_reg <= 1'b0;
            tag_reg       <= '0;
            got_reg       <= '0;
            status_reg    <= tdq_pkg::ST_OK;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (req_valid)
                    begin
                        tag_reg       <= req_tag;
                        got_reg       <= '0;
                        found_reg     <= 1'b0;
                        pend_reg      <= 1'b0;
                        match_any_reg <= (req.op != tdq_pkg::REQ_REMOVE);
                        status_reg    <= tdq_pkg::ST_OK;
                        unique case (req.op)
                            tdq_pkg::REQ_PUSH_BACK:
                            begin
                                state_reg <= RESULT;
                                if (req_tag != '0)
                                begin
                                    if (count_reg == CW'(LIST_DEPTH))
                                    begin
                                        status_reg <= tdq_pkg::ST_FULL;
                                    end
                                    else
                                    begin
                                        count_reg <= count_reg + 1'b1;
                                    end
                                end
                            end
                            tdq_pkg::REQ_POP_BACK,
                            tdq_pkg::REQ_POP_FRONT,
                            tdq_pkg::REQ_REMOVE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= tdq_pkg::ST_EMPTY;
                                    state_reg  <= RESULT;
                                end
                                else
                                begin
                                    // a back pop reads only the last entry
                                    rd_addr_reg <= (req.op == tdq_pkg::REQ_POP_BACK) ?
                                                   count_reg - 1'b1 : '0;
                                    state_reg   <= SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= RESULT;
                            end
                        endcase
                    end
                end
                SCAN:
                begin
                    pend_reg      <= issue;
                    pend_addr_reg <= rd_addr_reg[AW-1:0];
                    if (issue)
                    begin
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                    end
                    if (data_match)
                    begin
                        found_reg <= 1'b1;
                        got_reg   <= rd_data_reg;
                    end
                    if (scan_done)
                    begin
                        state_reg <= RESULT;
                        if (found_reg)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                        else
                        begin
                            status_reg <= tdq_pkg::ST_NOT_FOUND;
                        end
                    end
                end
                RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign req_ready  = (state_reg == IDLE);
    assign res_valid  = (state_reg == RESULT);
    assign res.tag    = TAG_OUT_W'(got_reg);
    assign res.status = status_reg;
    assign res.count  = CNT_OUT_W'(count_reg);

endmodule

`default_nettype wire

/* src/tag_deque_with_remove.sv */
// Ordered tag list with push back, pop back, pop front and remove by value.
// Input channel: in_valid / in_stall carry req_type and tag_in; a transfer
// takes place on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry tag_out, status and entry_count,
// one result per request, in request order.
// Tags live in a single memory with one registered read port and one write
// port; one entry is read per cycle.
// Work per request, with N the number of stored tags at the request:
//   push, or any request on an empty list: the result is formed without
//   a memory read;
//   pop back: one read of the last entry; pop front and remove: a walk
//   through all N entries in the memory that finds the entry and closes up.
// One request is worked on at a time; in_stall stays high meanwhile.
// The output register holds a finished result while out_stall is high and the
// next request is worked on behind it.
// Reset empties the list and drops any pending result; the memory is not
// cleared, entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module tag_deque_with_remove #(
    parameter int LIST_DEPTH = 16,
    parameter int TAG_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] tag_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      tag_out,
    output logic [1:0]       status,
    output logic [4:0]       entry_count
);

    tdq_pkg::request_t req;
    tdq_pkg::result_t  res;
    tdq_pkg::result_t  out_res_reg;
    logic              req_ready;
    logic              res_valid;
    logic              res_ready;
    logic              out_valid_reg;

    assign req.op  = tdq_pkg::req_t'(req_type);
    assign req.tag = tag_in;

    tdq_engine #(
        .LIST_DEPTH (LIST_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req       (req),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // advance the output register whenever it is empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign in_stall    = !req_ready;
    assign out_valid   = out_valid_reg;
    assign tag_out     = out_res_reg.tag;
    assign status      = out_res_reg.status;
    assign entry_count = out_res_reg.count;

`ifndef SYNTH
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while a previous one is still in progress");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tdq_pkg::ST_FULL) |-> entry_count == 5'(LIST_DEPTH))
        else $error("full status with a count below the depth");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tdq_pkg::ST_EMPTY) |-> entry_count == '0 && tag_out == '0)
        else $error("empty status with a tag or nonzero count");

    a_no_tag_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tdq_pkg::ST_NOT_FOUND) |-> tag_out == '0)
        else $error("tag returned for a failed removal");
`endif

endmodule

`default_nettype wire

/* tb/tb_tag_deque_with_remove.sv */
`timescale 1ns / 1ps

module tb_tag_deque_with_remove;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PCT     = 22;

    typedef struct packed {
        tdq_pkg::req_t    op;
        logic [15:0]      tag;
        logic             fixed;
        tdq_pkg::result_t want;
    } step_t;

    localparam int N_DIRECTED = 20;
    localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
        '{tdq_pkg::REQ_POP_BACK,  16'h0000, 1'b1, '{16'h0000, tdq_pkg::ST_EMPTY,     5'd0}},
        '{tdq_pkg::REQ_POP_FRONT, 16'h0000, 1'b1, '{16'h0000, tdq_pkg::ST_EMPTY,     5'd0}},
        '{tdq_pkg::REQ_REMOVE,    16'h1234, 1'b1, '{16'h0000, tdq_pkg::ST_EMPTY,     5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h0000, 1'b1, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'hFFFF, 1'b1, '{16'h0000, tdq_pkg::ST_OK,        5'd1}},
        '{tdq_pkg::REQ_REMOVE,    16'h0000, 1'b1, '{16'h0000, tdq_pkg::ST_NOT_FOUND, 5'd1}},
        '{tdq_pkg::REQ_POP_FRONT, 16'h0000, 1'b1, '{16'hFFFF, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h0001, 1'b1, '{16'h0000, tdq_pkg::ST_OK,        5'd1}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h8000, 1'b1, '{16'h0000, tdq_pkg::ST_OK,        5'd2}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h5A5A, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h8000, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'h0000, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_REMOVE,    16'h8000, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_REMOVE,    16'h7FFF, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_POP_BACK,  16'hFFFF, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_POP_FRONT, 16'h0000, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_REMOVE,    16'h5A5A, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_REMOVE,    16'h5A5A, 1'b1, '{16'h0000, tdq_pkg::ST_EMPTY,     5'd0}},
        '{tdq_pkg::REQ_PUSH_BACK, 16'hA5A5, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}},
        '{tdq_pkg::REQ_POP_BACK,  16'h0000, 1'b0, '{16'h0000, tdq_pkg::ST_OK,        5'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [15:0] tag_in;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] tag_out;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    logic [15:0]      shadow_tags [DEPTH];
    int               shadow_count;
    tdq_pkg::result_t pending_results [$];
    int               failures;
    int               cycle_count = 0;
    logic             calm;
    logic             hold_go;
    logic             hold_rx;

    tag_deque_with_remove u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .tag_in      (tag_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tag_out     (tag_out),
        .status      (status),
        .entry_count (entry_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one request to the shadow list and return what the block should report.
    function automatic tdq_pkg::result_t apply_request(tdq_pkg::req_t op, logic [15:0] tag);
        tdq_pkg::result_t r;
        int               hit;
        int               i;
        r.tag    = '0;
        r.status = tdq_pkg::ST_OK;
        hit      = -1;
        case (op)
            tdq_pkg::REQ_PUSH_BACK:
            begin
                if (tag != '0)
                begin
                    if (shadow_count >= DEPTH)
                        r.status = tdq_pkg::ST_FULL;
                    else
                    begin
                        shadow_tags[shadow_count] = tag;
                        shadow_count++;
                    end
                end
            end
            tdq_pkg::REQ_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.status = tdq_pkg::ST_EMPTY;
                else
                begin
                    r.tag = shadow_tags[shadow_count - 1];
                    shadow_count--;
                end
            end
            tdq_pkg::REQ_POP_FRONT:
            begin
                if (shadow_count == 0)
                    r.status = tdq_pkg::ST_EMPTY;
                else
                    hit = 0;
            end
            default:
            begin
                if (shadow_count == 0)
                    r.status = tdq_pkg::ST_EMPTY;
                else
                begin
                    r.status = tdq_pkg::ST_NOT_FOUND;
                    for (i = 0; i < shadow_count; i++)
                        if (hit < 0 && tag != '0 && shadow_tags[i] == tag)
                            hit = i;
                    if (hit >= 0)
                        r.status = tdq_pkg::ST_OK;
                end
            end
        endcase
        // close up behind the entry taken out
        if (hit >= 0)
        begin
            r.tag = shadow_tags[hit];
            for (i = hit; i < shadow_count - 1; i++)
                shadow_tags[i] = shadow_tags[i + 1];
            shadow_count--;
        end
        r.count = 5'(shadow_count);
        return r;
    endfunction

    function automatic tdq_pkg::req_t pick_request(int mode);
        int k;
        k = $urandom_range(99);
        case (mode)
            0:       return tdq_pkg::req_t'(k < 70 ? tdq_pkg::REQ_PUSH_BACK :
                                            k < 80 ? tdq_pkg::REQ_POP_BACK :
                                            k < 90 ? tdq_pkg::REQ_POP_FRONT :
                                                     tdq_pkg::REQ_REMOVE);
            1:       return tdq_pkg::req_t'(k < 20 ? tdq_pkg::REQ_PUSH_BACK :
                                            k < 50 ? tdq_pkg::REQ_POP_BACK :
                                            k < 80 ? tdq_pkg::REQ_POP_FRONT :
                                                     tdq_pkg::REQ_REMOVE);
            default: return tdq_pkg::req_t'(k < 40 ? tdq_pkg::REQ_PUSH_BACK :
                                            k < 50 ? tdq_pkg::REQ_POP_BACK :
                                            k < 65 ? tdq_pkg::REQ_POP_FRONT :
                                                     tdq_pkg::REQ_REMOVE);
        endcase
    endfunction

    // Small values give duplicates and hits; wide ones toggle every bit.
    function automatic logic [15:0] pick_tag(tdq_pkg::req_t op);
        int k;
        k = $urandom_range(99);
        if (op == tdq_pkg::REQ_REMOVE && k < 60 && shadow_count > 0)
            return shadow_tags[$urandom_range(shadow_count - 1)];
        if (k < 70 && k >= 60 || k < 8)
            return '0;
        if (k < 40)
            return 16'($urandom_range(6, 1));
        return 16'($urandom_range(65535));
    endfunction

    task automatic offer_request(tdq_pkg::req_t op, logic [15:0] tag, logic fixed,
                                 tdq_pkg::result_t want, logic no_idle);
        tdq_pkg::result_t predicted;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        req_type <= op;
        tag_in   <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_request(op, tag);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    initial
    begin
        int               n;
        tdq_pkg::req_t    op;
        tdq_pkg::result_t blank;
        blank    = '0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = tdq_pkg::REQ_PUSH_BACK;
        tag_in   = '0;
        calm     = 1'b0;
        hold_go  = 1'b0;
        shadow_count = 0;
        failures = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_DIRECTED; n++)
            offer_request(DIRECTED_STEPS[n].op, DIRECTED_STEPS[n].tag,
                          DIRECTED_STEPS[n].fixed, DIRECTED_STEPS[n].want, 1'b0);

        // cycle through fill, drain and churn so the list hits full and empty often
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 250)
                hold_go <= 1'b1;
            if (n == 500)
                calm <= 1'b1;
            if (n == 700)
                calm <= 1'b0;
            op = pick_request((n / 60) % 3);
            offer_request(op, pick_tag(op), 1'b0, blank, n >= 500 && n < 700);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hold off the output long enough for the block to back up into its input.
    initial
    begin
        hold_rx = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        tdq_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: tag %h status %0d count %0d",
                       tag_out, status, entry_count);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (tag_out !== want.tag)
                begin
                    $error("tag_out: expected %h, got %h", want.tag, tag_out);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    failures++;
                end
            end
        end
        if (hold_rx)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
